@@ rtl/jgpt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jgpt_pkg
// Shared constants for the jittered grid point test: hash multipliers, salts,
// register indexes and datapath widths.
// ----------------------------------------------------------------------------
package jgpt_pkg;

   // datapath widths
   localparam int DATA_W            = 32;
   localparam int SPACING_W         = 8;
   localparam int CSR_INDEX_W       = 2;
   localparam int DIV_STEP_BITS_DEF = 4;
   localparam int HASH_LANES        = 3;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WORLD_SEED        = 2'd0,
      CSR_DENSITY_THRESHOLD = 2'd1,
      CSR_CELL_SPACING      = 2'd2
   } csr_index_type;

   // cell mixing multipliers
   localparam logic [DATA_W-1:0] MIX_CX   = 32'h9e37_79b9;
   localparam logic [DATA_W-1:0] MIX_CZ   = 32'h85eb_ca6b;
   localparam logic [DATA_W-1:0] MIX_SEED = 32'hc2b2_ae35;

   // finalizer multipliers
   localparam logic [DATA_W-1:0] FIN_MUL_A = 32'h7feb_352d;
   localparam logic [DATA_W-1:0] FIN_MUL_B = 32'h846c_a68b;

   // salts: activity lane, x offset lane, z offset lane
   localparam logic [DATA_W-1:0] SALT_NONE = 32'h0000_0000;
   localparam logic [DATA_W-1:0] SALT_X    = 32'h68bc_21eb;
   localparam logic [DATA_W-1:0] SALT_Z    = 32'h02e5_be93;

   // reset values of the registers
   localparam logic [DATA_W-1:0]    SEED_RESET      = 32'd0;
   localparam logic [DATA_W-1:0]    THRESHOLD_RESET = 32'd1503238553;
   localparam logic [SPACING_W-1:0] SPACING_RESET   = 8'd5;

endpackage
`default_nettype wire

@@ rtl/jittered_grid_point_test_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jittered_grid_point_test_unit
// Decides whether a world coordinate is the jittered point of its grid cell:
// floor division into cells, hashed cell activity and hashed point offsets.
// ----------------------------------------------------------------------------
//  channel | direction | beat contents
//  req_    | in        | coord_x, coord_z (signed 32 bit)
//  rsp_    | out       | is_point (1 bit)
//  csr_    | in        | index 0 seed, 1 density threshold, 2 cell spacing
//
//  one beat in and one beat out per cycle unless the result is held;
//  a beat passes the input register, the cell divider pipe, the cell,
//  mixing, fold, finalizer and hash stages, offset divider and result.
//  reset clears all valid bits and restores the register defaults.
//  a stalled result freezes the whole pipe; req_ready follows that freeze.
// ----------------------------------------------------------------------------
module jittered_grid_point_test_unit
   import jgpt_pkg::*;
#(
   parameter int DIV_STEP_BITS = DIV_STEP_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic signed [DATA_W-1:0] req_coord_x,
   input  wire logic signed [DATA_W-1:0] req_coord_z,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic                        rsp_is_point,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [DATA_W-1:0]      csr_data
);

   // configuration registers
   logic [DATA_W-1:0]    seed_ff;
   logic [DATA_W-1:0]    thresh_ff;
   logic [SPACING_W-1:0] spacing_ff;
   logic [SPACING_W-1:0] sp_eff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff    <= SEED_RESET;
         thresh_ff  <= THRESHOLD_RESET;
         spacing_ff <= SPACING_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_WORLD_SEED:        seed_ff    <= csr_data;
            CSR_DENSITY_THRESHOLD: thresh_ff  <= csr_data;
            CSR_CELL_SPACING:      spacing_ff <= csr_data[SPACING_W-1:0];
            default: ;
         endcase
      end
   end

   // zero spacing acts as one
   assign sp_eff = (spacing_ff == '0) ? SPACING_W'(1) : spacing_ff;

   // global advance: pipe moves unless the result is held
   logic adv;
   logic rsp_valid_ff;
   logic rsp_point_ff;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // input stage
   logic              in_vld_ff;
   logic [DATA_W-1:0] x_ff;
   logic [DATA_W-1:0] z_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff <= req_coord_x;
         z_ff <= req_coord_z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (adv) begin
         in_vld_ff <= req_valid;
      end
   end

   // floor division: negative values divide their complement
   logic [DATA_W-1:0]    ax;
   logic [DATA_W-1:0]    az;
   logic                 d1_vld;
   logic [DATA_W-1:0]    d1_qx;
   logic [DATA_W-1:0]    d1_qz;
   logic [SPACING_W-1:0] d1_rx;
   logic [SPACING_W-1:0] d1_rz;
   logic [1:0]           d1_sign;

   assign ax = x_ff[DATA_W-1] ? ~x_ff : x_ff;
   assign az = z_ff[DATA_W-1] ? ~z_ff : z_ff;

   jgpt_div_pipe #(
      .DATA_W_P    (DATA_W),
      .STEP_BITS_P (DIV_STEP_BITS),
      .SIDE_W_P    (2)
   ) u_cell_div (
      .clock      (clock),
      .reset      (reset),
      .en         (adv),
      .in_valid   (in_vld_ff),
      .divisor    (sp_eff),
      .dividend_a (ax),
      .dividend_b (az),
      .side_in    ({x_ff[DATA_W-1], z_ff[DATA_W-1]}),
      .out_valid  (d1_vld),
      .quo_a      (d1_qx),
      .rem_a      (d1_rx),
      .quo_b      (d1_qz),
      .rem_b      (d1_rz),
      .side_out   (d1_sign)
   );

   // cell index and offset within cell
   logic                 c_vld_ff;
   logic [DATA_W-1:0]    cx_ff;
   logic [DATA_W-1:0]    cz_ff;
   logic [SPACING_W-1:0] rx_c_ff;
   logic [SPACING_W-1:0] rz_c_ff;
   logic [SPACING_W-1:0] sp_m1;

   assign sp_m1 = sp_eff - SPACING_W'(1);

   always_ff @(posedge clock) begin
      if (adv) begin
         cx_ff   <= d1_sign[1] ? ~d1_qx : d1_qx;
         cz_ff   <= d1_sign[0] ? ~d1_qz : d1_qz;
         rx_c_ff <= d1_sign[1] ? (sp_m1 - d1_rx) : d1_rx;
         rz_c_ff <= d1_sign[0] ? (sp_m1 - d1_rz) : d1_rz;
      end
   end

   // mixing products
   logic                 m_vld_ff;
   logic [DATA_W-1:0]    px_ff;
   logic [DATA_W-1:0]    pz_ff;
   logic [DATA_W-1:0]    ps_ff;
   logic [SPACING_W-1:0] rx_m_ff;
   logic [SPACING_W-1:0] rz_m_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         px_ff   <= cx_ff * MIX_CX;
         pz_ff   <= cz_ff * MIX_CZ;
         ps_ff   <= seed_ff * MIX_SEED;
         rx_m_ff <= rx_c_ff;
         rz_m_ff <= rz_c_ff;
      end
   end

   // three hash lanes: activity, x offset, z offset
   logic [DATA_W-1:0] salt [HASH_LANES];
   logic [DATA_W-1:0] mixed;
   logic [DATA_W-1:0] u_ff  [HASH_LANES];
   logic [DATA_W-1:0] f1_ff [HASH_LANES];
   logic [DATA_W-1:0] f2_ff [HASH_LANES];
   logic [DATA_W-1:0] h_ff  [HASH_LANES];
   logic [DATA_W-1:0] f1_x  [HASH_LANES];

   assign salt[0] = SALT_NONE;
   assign salt[1] = SALT_X;
   assign salt[2] = SALT_Z;
   assign mixed   = px_ff ^ pz_ff ^ ps_ff;

   for (genvar k = 0; k < HASH_LANES; k++) begin : g_lane
      assign f1_x[k] = f1_ff[k] ^ (f1_ff[k] >> 15);

      // salt and first fold, then the finalizer multiplies
      always_ff @(posedge clock) begin
         if (adv) begin
            u_ff[k]  <= (mixed ^ salt[k]) ^ ((mixed ^ salt[k]) >> 16);
            f1_ff[k] <= u_ff[k] * FIN_MUL_A;
            f2_ff[k] <= f1_x[k] * FIN_MUL_B;
            h_ff[k]  <= f2_ff[k] ^ (f2_ff[k] >> 16);
         end
      end
   end

   // offsets carried beside the hash lanes
   logic [SPACING_W-1:0] rx_u_ff;
   logic [SPACING_W-1:0] rz_u_ff;
   logic [SPACING_W-1:0] rx_f1_ff;
   logic [SPACING_W-1:0] rz_f1_ff;
   logic [SPACING_W-1:0] rx_f2_ff;
   logic [SPACING_W-1:0] rz_f2_ff;
   logic [SPACING_W-1:0] rx_h_ff;
   logic [SPACING_W-1:0] rz_h_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         rx_u_ff  <= rx_m_ff;
         rz_u_ff  <= rz_m_ff;
         rx_f1_ff <= rx_u_ff;
         rz_f1_ff <= rz_u_ff;
         rx_f2_ff <= rx_f1_ff;
         rz_f2_ff <= rz_f1_ff;
         rx_h_ff  <= rx_f2_ff;
         rz_h_ff  <= rz_f2_ff;
      end
   end

   // valid bits through the hash stages
   logic u_vld_ff;
   logic f1_vld_ff;
   logic f2_vld_ff;
   logic h_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff  <= 1'b0;
         m_vld_ff  <= 1'b0;
         u_vld_ff  <= 1'b0;
         f1_vld_ff <= 1'b0;
         f2_vld_ff <= 1'b0;
         h_vld_ff  <= 1'b0;
      end else if (adv) begin
         c_vld_ff  <= d1_vld;
         m_vld_ff  <= c_vld_ff;
         u_vld_ff  <= m_vld_ff;
         f1_vld_ff <= u_vld_ff;
         f2_vld_ff <= f1_vld_ff;
         h_vld_ff  <= f2_vld_ff;
      end
   end

   // cell activity and point offsets modulo the spacing
   logic                          active;
   logic                          d2_vld;
   logic [DATA_W-1:0]             d2_qx;
   logic [DATA_W-1:0]             d2_qz;
   logic [SPACING_W-1:0]          ox;
   logic [SPACING_W-1:0]          oz;
   logic [2*SPACING_W:0]          d2_side;

   assign active = (thresh_ff != '0) && (h_ff[0] <= thresh_ff);

   jgpt_div_pipe #(
      .DATA_W_P    (DATA_W),
      .STEP_BITS_P (DIV_STEP_BITS),
      .SIDE_W_P    (2*SPACING_W + 1)
   ) u_offset_div (
      .clock      (clock),
      .reset      (reset),
      .en         (adv),
      .in_valid   (h_vld_ff),
      .divisor    (sp_eff),
      .dividend_a (h_ff[1]),
      .dividend_b (h_ff[2]),
      .side_in    ({active, rx_h_ff, rz_h_ff}),
      .out_valid  (d2_vld),
      .quo_a      (d2_qx),
      .rem_a      (ox),
      .quo_b      (d2_qz),
      .rem_b      (oz),
      .side_out   (d2_side)
   );

   // quotients of the offset divide carry no information here
   logic d2_unused;
   assign d2_unused = ^{d2_qx, d2_qz};

   // result register
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_point_ff <= d2_side[2*SPACING_W]
                       && (ox == d2_side[2*SPACING_W-1:SPACING_W])
                       && (oz == d2_side[SPACING_W-1:0])
                       && (d2_unused || !d2_unused);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= d2_vld;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_point = rsp_point_ff;

endmodule
`default_nettype wire

@@ rtl/jgpt_div_pipe.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jgpt_div_pipe
// Two-lane pipelined restoring divider by a shared 8-bit divisor. Each stage
// retires a fixed number of quotient bits; a sideband word and a valid bit
// travel alongside. The whole pipe advances only when en is high.
// ----------------------------------------------------------------------------
module jgpt_div_pipe
   import jgpt_pkg::*;
#(
   parameter int DATA_W_P    = DATA_W,
   parameter int STEP_BITS_P = DIV_STEP_BITS_DEF,
   parameter int SIDE_W_P    = 1
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 en,
   input  wire logic                 in_valid,
   input  wire logic [SPACING_W-1:0] divisor,
   input  wire logic [DATA_W_P-1:0]  dividend_a,
   input  wire logic [DATA_W_P-1:0]  dividend_b,
   input  wire logic [SIDE_W_P-1:0]  side_in,
   output logic                      out_valid,
   output logic [DATA_W_P-1:0]       quo_a,
   output logic [SPACING_W-1:0]      rem_a,
   output logic [DATA_W_P-1:0]       quo_b,
   output logic [SPACING_W-1:0]      rem_b,
   output logic [SIDE_W_P-1:0]       side_out
);

   localparam int NS = DATA_W_P / STEP_BITS_P;
   localparam int WK = DATA_W_P + SPACING_W;

   // work word: partial remainder on top, dividend shifting out / quotient in
   logic [WK-1:0]       work_a_ff [NS];
   logic [WK-1:0]       work_b_ff [NS];
   logic [SIDE_W_P-1:0] side_ff   [NS];
   logic [NS-1:0]       vld_ff;

   // a few restoring steps on one work word
   function automatic logic [WK-1:0] div_steps(input logic [WK-1:0]        w_in,
                                               input logic [SPACING_W-1:0] d);
      logic [WK-1:0]      w;
      logic [SPACING_W:0] t;
      logic [SPACING_W:0] diff;
      logic               ge;
      w = w_in;
      for (int b = 0; b < STEP_BITS_P; b++) begin
         t    = {w[WK-1:DATA_W_P], w[DATA_W_P-1]};
         diff = t - {1'b0, d};
         ge   = (t >= {1'b0, d});
         w[DATA_W_P-1:0]  = {w[DATA_W_P-2:0], ge};
         w[WK-1:DATA_W_P] = ge ? diff[SPACING_W-1:0] : t[SPACING_W-1:0];
      end
      return w;
   endfunction

   for (genvar s = 0; s < NS; s++) begin : g_stage
      logic [WK-1:0]       a_cur;
      logic [WK-1:0]       b_cur;
      logic [SIDE_W_P-1:0] s_cur;
      logic                v_cur;

      // stage input
      if (s == 0) begin : g_first
         assign a_cur = {{SPACING_W{1'b0}}, dividend_a};
         assign b_cur = {{SPACING_W{1'b0}}, dividend_b};
         assign s_cur = side_in;
         assign v_cur = in_valid;
      end else begin : g_next
         assign a_cur = work_a_ff[s-1];
         assign b_cur = work_b_ff[s-1];
         assign s_cur = side_ff[s-1];
         assign v_cur = vld_ff[s-1];
      end

      // stage payload
      always_ff @(posedge clock) begin
         if (en) begin
            work_a_ff[s] <= div_steps(a_cur, divisor);
            work_b_ff[s] <= div_steps(b_cur, divisor);
            side_ff[s]   <= s_cur;
         end
      end

      // stage valid
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= v_cur;
         end
      end
   end

   // last stage out
   assign out_valid = vld_ff[NS-1];
   assign quo_a     = work_a_ff[NS-1][DATA_W_P-1:0];
   assign rem_a     = work_a_ff[NS-1][WK-1:DATA_W_P];
   assign quo_b     = work_b_ff[NS-1][DATA_W_P-1:0];
   assign rem_b     = work_b_ff[NS-1][WK-1:DATA_W_P];
   assign side_out  = side_ff[NS-1];

endmodule
`default_nettype wire

@@ tb/tb_jittered_grid_point_test_unit.sv @@
// ----------------------------------------------------------------------------
// tb_jittered_grid_point_test_unit
// Streams world coordinates through the grid point tester under several seed,
// threshold and spacing settings. A scoreboard predicts each is_point beat from
// its own copy of the registers, and both channels stall at random.
// ----------------------------------------------------------------------------
module tb_jittered_grid_point_test_unit
   import jgpt_pkg::*;
();

   // grid point predictor and expected result store
   class point_scoreboard;
      logic [DATA_W-1:0]    seed;
      logic [DATA_W-1:0]    threshold;
      logic [SPACING_W-1:0] spacing;
      bit                   pending_hits[$];
      int                   errors;
      int                   results;
      int                   hits;

      function new();
         seed      = SEED_RESET;
         threshold = THRESHOLD_RESET;
         spacing   = SPACING_RESET;
         errors    = 0;
         results   = 0;
         hits      = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [DATA_W-1:0] data);
         case (idx)
            CSR_WORLD_SEED:        seed      = data;
            CSR_DENSITY_THRESHOLD: threshold = data;
            CSR_CELL_SPACING:      spacing   = data[SPACING_W-1:0];
            default: ;
         endcase
      endfunction

      function longint eff_spacing();
         return (spacing == 0) ? 1 : longint'(spacing);
      endfunction

      function logic [31:0] mix_cell(logic [31:0] cx, logic [31:0] cz, logic [31:0] salt);
         logic [31:0] v;
         v = (cx * MIX_CX) ^ (cz * MIX_CZ) ^ (seed * MIX_SEED) ^ salt;
         v = v ^ (v >> 16);
         v = v * FIN_MUL_A;
         v = v ^ (v >> 15);
         v = v * FIN_MUL_B;
         v = v ^ (v >> 16);
         return v;
      endfunction

      // floor division; remainder always in [0, spacing)
      function longint cell_of(longint a, output longint rem);
         longint d, q, r;
         d = eff_spacing();
         q = a / d;
         r = a % d;
         if (r < 0) begin
            q = q - 1;
            r = r + d;
         end
         rem = r;
         return q;
      endfunction

      function bit cell_active(logic [31:0] cx, logic [31:0] cz);
         return threshold != 0 && mix_cell(cx, cz, SALT_NONE) <= threshold;
      endfunction

      function bit predict_hit(logic signed [31:0] x, logic signed [31:0] z);
         longint rx, rz, cx, cz, sp;
         logic [31:0] ox, oz;
         sp = eff_spacing();
         cx = cell_of(longint'(x), rx);
         cz = cell_of(longint'(z), rz);
         if (!cell_active(cx[31:0], cz[31:0])) return 0;
         ox = mix_cell(cx[31:0], cz[31:0], SALT_X) % sp[31:0];
         oz = mix_cell(cx[31:0], cz[31:0], SALT_Z) % sp[31:0];
         return (rx[31:0] == ox) && (rz[31:0] == oz);
      endfunction

      // move a coordinate onto its cell's jitter point when that stays in range
      function logic signed [31:0] snap_to_point(logic signed [31:0] a, logic [31:0] salt,
                                                 logic signed [31:0] other, bit is_x);
         longint ra, ro, ca, co, sp, p;
         logic [31:0] off;
         sp = eff_spacing();
         ca = cell_of(longint'(a), ra);
         co = cell_of(longint'(other), ro);
         off = is_x ? mix_cell(ca[31:0], co[31:0], salt) : mix_cell(co[31:0], ca[31:0], salt);
         p = ca * sp + longint'(off % sp[31:0]);
         if (p > 64'sd2147483647 || p < -64'sd2147483648) return a;
         return p[31:0];
      endfunction

      function void note_request(logic signed [31:0] x, logic signed [31:0] z);
         pending_hits.push_back(predict_hit(x, z));
      endfunction

      function void check_result(bit is_point);
         bit want;
         results++;
         if (is_point) hits++;
         if (pending_hits.size() == 0) begin
            $error("is_point beat with nothing expected: actual %0b", is_point);
            errors++;
            return;
         end
         want = pending_hits.pop_front();
         if (want != is_point) begin
            $error("is_point mismatch: expected %0b actual %0b", want, is_point);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic signed [DATA_W-1:0] req_coord_x;
   logic signed [DATA_W-1:0] req_coord_z;
   logic rsp_valid;
   logic rsp_ready;
   logic rsp_is_point;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [DATA_W-1:0] csr_data;

   point_scoreboard sb = new();
   bit no_stall = 0;
   int sent = 0;

   jittered_grid_point_test_unit u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_coord_x  (req_coord_x),
      .req_coord_z  (req_coord_z),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_is_point (rsp_is_point),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   // clock
   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // run limit
   initial begin
      #(20 * 2000000);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // mostly short gaps, now and then a long one
   function int pick_gap();
      int r;
      if (no_stall) return 0;
      r = $urandom_range(99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // result side stalls
   initial begin
      int n;
      rsp_ready = 0;
      @(posedge clock);
      forever begin
         rsp_ready <= 1;
         repeat ($urandom_range(12, 1)) @(posedge clock);
         n = pick_gap();
         if (n > 0) begin
            rsp_ready <= 0;
            repeat (n) @(posedge clock);
         end
      end
   end

   // result beat check
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_is_point);
   end

   task automatic send_coord(logic signed [31:0] x, logic signed [31:0] z);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1;
      req_coord_x <= x;
      req_coord_z <= z;
      do @(posedge clock); while (!req_ready);
      sb.note_request(x, z);
      sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 0;
      while (sb.pending_hits.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [DATA_W-1:0] data);
      wait_drained();
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      sb.write_reg(idx, data);
   endtask

   // random coordinates, most of them aimed at a cell's jitter point
   task automatic random_burst(int count);
      logic signed [31:0] x, z;
      int kind;
      repeat (count) begin
         kind = $urandom_range(99);
         if (kind < 20) begin
            x = $urandom;
            z = $urandom;
         end else begin
            if (kind < 60) begin
               x = $urandom_range(2000) - 1000;
               z = $urandom_range(2000) - 1000;
            end else begin
               x = $urandom;
               z = $urandom;
            end
            if (kind % 4 != 0) begin
               x = sb.snap_to_point(x, SALT_X, z, 1);
               z = sb.snap_to_point(z, SALT_Z, x, 0);
            end else begin
               x = x + $signed($urandom_range(2)) - 1;
            end
         end
         send_coord(x, z);
      end
   endtask

   initial begin
      reset       = 1;
      req_valid   = 0;
      req_coord_x = 0;
      req_coord_z = 0;
      csr_valid   = 0;
      csr_index   = CSR_WORLD_SEED;
      csr_data    = 0;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: field extremes at reset settings
      no_stall = 1;
      send_coord(32'sh8000_0000, 32'sh8000_0000);
      send_coord(32'sh7fff_ffff, 32'sh7fff_ffff);
      send_coord(32'sh8000_0000, 32'sh7fff_ffff);
      send_coord(0, 0);
      send_coord(-1, -1);
      send_coord(4, -5);
      no_stall = 0;

      // zero threshold disables every point
      write_csr(CSR_DENSITY_THRESHOLD, 32'd0);
      send_coord(sb.snap_to_point(0, SALT_X, 0, 1), sb.snap_to_point(0, SALT_Z, 0, 0));
      send_coord(3, 7);
      // full threshold, every cell active
      write_csr(CSR_DENSITY_THRESHOLD, 32'hffff_ffff);
      write_csr(CSR_WORLD_SEED, 32'h8000_0000);
      send_coord(sb.snap_to_point(-7, SALT_X, 9, 1), sb.snap_to_point(9, SALT_Z, -7, 0));
      send_coord(32'sh7fff_ffff, 32'sh8000_0000);
      // zero spacing acts as one: every coordinate is a point
      write_csr(CSR_CELL_SPACING, 32'd0);
      send_coord(32'sh8000_0000, 32'sh7fff_ffff);
      send_coord(12345, -54321);
      // widest spacing near the ends of the range
      write_csr(CSR_CELL_SPACING, 32'hffff_ffff);
      send_coord(32'sh7fff_fff0, 32'sh8000_0005);
      send_coord(sb.snap_to_point(32'sh7fff_ff80, SALT_X, 32'sh8000_0010, 1),
                 sb.snap_to_point(32'sh8000_0010, SALT_Z, 32'sh7fff_ff80, 0));
      // unused register index is ignored
      write_csr(2'd3, $urandom);
      send_coord(100, 200);

      // random phases over several settings
      write_csr(CSR_WORLD_SEED, 32'h7fff_ffff);
      write_csr(CSR_DENSITY_THRESHOLD, THRESHOLD_RESET);
      write_csr(CSR_CELL_SPACING, 32'd5);
      random_burst(150);
      wait_drained();
      random_burst(100);
      write_csr(CSR_CELL_SPACING, 32'd1);
      random_burst(150);
      write_csr(CSR_WORLD_SEED, $urandom);
      write_csr(CSR_CELL_SPACING, 32'd255);
      write_csr(CSR_DENSITY_THRESHOLD, 32'hffff_ffff);
      random_burst(150);
      write_csr(CSR_DENSITY_THRESHOLD, 32'd0);
      random_burst(100);
      no_stall = 1;
      write_csr(CSR_DENSITY_THRESHOLD, $urandom);
      write_csr(CSR_CELL_SPACING, $urandom_range(16, 2));
      random_burst(150);
      no_stall = 0;
      repeat (4) begin
         write_csr(CSR_WORLD_SEED, $urandom);
         write_csr(CSR_DENSITY_THRESHOLD, $urandom);
         write_csr(CSR_CELL_SPACING, $urandom_range(255, 1));
         random_burst(140);
      end

      // drain
      req_valid <= 0;
      while (sb.pending_hits.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Sent %0d coordinates, checked %0d results (%0d points found)",
               sent, sb.results, sb.hits);
      $display("Settings covered zero/full threshold, zero/unit/max spacing, extreme seeds");
      if (sb.errors == 0 && sb.pending_hits.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
